// File: hdl/minimum_spanning_tree_weight_unit_defines.svh
// Assertion macros for the minimum spanning tree weight unit
`ifndef MINIMUM_SPANNING_TREE_WEIGHT_UNIT_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_WEIGHT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define MSTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MSTW_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MSTW_ASSERT(label, prop, msg)
`define MSTW_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: hdl/mstw_pkg.sv
package mstw_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 256;
  localparam int DEF_WEIGHT_BITS  = 16;
  localparam int SUM_W            = 22;

  typedef struct packed {
    logic accept;
    logic load;
    logic init_step;
    logic scan_clr;
    logic min_eval;
    logic take_min;
    logic pick_skip;
    logic find_start;
    logic par_step;
    logic root_a;
    logic unite;
    logic emit;
  } mstw_cmd_t;

  typedef struct packed {
    logic last;
    logic init_done;
    logic i_end;
    logic found;
    logic pick_hit;
    logic at_root;
    logic out_free;
  } mstw_status_t;

endpackage

// File: hdl/mstw_if.sv
interface mstw_edge_if #(
  parameter int VTX_W = 7,
  parameter int WEIGHT_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [VTX_W-1:0]              end_one;
  logic [VTX_W-1:0]              end_two;
  logic signed [WEIGHT_BITS-1:0] edge_weight;
  logic                          last_edge;

  modport source (output valid, end_one, end_two, edge_weight, last_edge, input ready);
  modport sink (input valid, end_one, end_two, edge_weight, last_edge, output ready);
endinterface

interface mstw_result_if #(
  parameter int SUM_W = 22
);
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] tree_weight;
  logic                    spanning;
  logic                    overflow;

  modport source (output valid, tree_weight, spanning, overflow, input ready);
  modport sink (input valid, tree_weight, spanning, overflow, output ready);
endinterface

// File: hdl/mstw_ctrl.sv
module mstw_ctrl
  import mstw_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  mstw_status_t status_i,
  output mstw_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_INIT   = 11'b00000000010,
    S_MIN_A  = 11'b00000000100,
    S_MIN_B  = 11'b00000001000,
    S_PICK_A = 11'b00000010000,
    S_PICK_B = 11'b00000100000,
    S_FA1    = 11'b00001000000,
    S_FB1    = 11'b00010000000,
    S_FA2    = 11'b00100000000,
    S_FB2    = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.last) state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (status_i.init_done) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = S_MIN_A;
        end
      end
      S_MIN_A: begin
        if (status_i.i_end) begin
          if (status_i.found) begin
            cmd_o.take_min = 1'b1;
            state_d        = S_PICK_A;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_MIN_B;
        end
      end
      S_MIN_B: begin
        cmd_o.min_eval = 1'b1;
        state_d        = S_MIN_A;
      end
      S_PICK_A: begin
        if (status_i.i_end) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = S_MIN_A;
        end else begin
          state_d = S_PICK_B;
        end
      end
      S_PICK_B: begin
        if (status_i.pick_hit) begin
          cmd_o.find_start = 1'b1;
          state_d          = S_FA1;
        end else begin
          cmd_o.pick_skip = 1'b1;
          state_d         = S_PICK_A;
        end
      end
      S_FA1: state_d = S_FB1;
      S_FB1: begin
        if (status_i.at_root) begin
          cmd_o.root_a = 1'b1;
          state_d      = S_FA2;
        end else begin
          cmd_o.par_step = 1'b1;
          state_d        = S_FA1;
        end
      end
      S_FA2: state_d = S_FB2;
      S_FB2: begin
        if (status_i.at_root) begin
          cmd_o.unite = 1'b1;
          state_d     = S_PICK_A;
        end else begin
          cmd_o.par_step = 1'b1;
          state_d        = S_FA2;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/mstw_datapath.sv
module mstw_datapath
  import mstw_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS,
  localparam int VTX_W       = $clog2(MAX_VERTICES + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [VTX_W-1:0] cfg_wdata_i,
  mstw_edge_if.sink    item_i,
  mstw_result_if.source result_o,
  input  mstw_cmd_t    cmd_i,
  output mstw_status_t status_o
);

  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int EW = 2 * VTX_W + WEIGHT_BITS;
  localparam int AW = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;
  localparam logic [VTX_W-1:0] VMAX = VTX_W'(MAX_VERTICES);
  localparam logic signed [AW-1:0] SUM_HI = AW'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SUM_LO = AW'(-(64'sd1 <<< (SUM_W - 1)));

  logic [EW-1:0]    edge_mem [MAX_EDGES];
  logic [VTX_W-1:0] par_mem  [MAX_VERTICES + 1];

  logic [VTX_W-1:0] vcount_q;
  logic [CW-1:0]    total_q, i_q;
  logic             dropped_q, have_q, found_q;
  logic [VTX_W-1:0] k_q, x_q, ra_q, joins_q;
  logic signed [WEIGHT_BITS-1:0] cur_q, best_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [EW-1:0]    edata_q;
  logic [VTX_W-1:0] pdata_q;
  logic             out_valid_q;
  logic signed [SUM_W-1:0] out_weight_q;
  logic             out_span_q, out_ovf_q;

  logic [VTX_W-1:0] n_eff, e_u, e_v;
  logic signed [WEIGHT_BITS-1:0] e_w;
  logic             u_ok, v_ok, cand, do_union, span;
  logic signed [AW-1:0] sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  assign n_eff = (vcount_q == '0) ? VTX_W'(1) : ((vcount_q > VMAX) ? VMAX : vcount_q);
  assign e_u   = edata_q[EW-1 -: VTX_W];
  assign e_v   = edata_q[WEIGHT_BITS+VTX_W-1 -: VTX_W];
  assign e_w   = edata_q[WEIGHT_BITS-1:0];
  assign u_ok  = (e_u != '0) && (e_u <= n_eff);
  assign v_ok  = (e_v != '0) && (e_v <= n_eff);
  assign cand  = (!have_q || (e_w > cur_q)) && (!found_q || (e_w < best_q));
  assign do_union = cmd_i.unite && (ra_q != x_q);
  assign span  = (joins_q == n_eff - VTX_W'(1));

  assign sum_wide = AW'(sum_q) + AW'(e_w);
  assign sum_sat  = (sum_wide > SUM_HI) ? SUM_W'(SUM_HI) :
                    ((sum_wide < SUM_LO) ? SUM_W'(SUM_LO) : SUM_W'(sum_wide));

  assign status_o.last      = item_i.last_edge;
  assign status_o.init_done = (k_q == n_eff);
  assign status_o.i_end     = (i_q == total_q);
  assign status_o.found     = found_q;
  assign status_o.pick_hit  = (e_w == cur_q) && u_ok && v_ok;
  assign status_o.at_root   = (pdata_q == x_q);
  assign status_o.out_free  = !out_valid_q || result_o.ready;

  assign item_i.ready         = cmd_i.accept;
  assign result_o.valid       = out_valid_q;
  assign result_o.tree_weight = out_weight_q;
  assign result_o.spanning    = out_span_q;
  assign result_o.overflow    = out_ovf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (total_q < CW'(MAX_EDGES))) begin
      edge_mem[total_q[EA-1:0]] <= {item_i.end_one, item_i.end_two, item_i.edge_weight};
    end
    edata_q <= edge_mem[i_q[EA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      par_mem[k_q] <= k_q;
    end else if (do_union) begin
      par_mem[x_q] <= ra_q;
    end
    pdata_q <= par_mem[x_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.min_eval && cand) best_q <= e_w;
    if (cmd_i.take_min) cur_q <= best_q;
    if (cmd_i.find_start) x_q <= e_u;
    else if (cmd_i.par_step) x_q <= pdata_q;
    else if (cmd_i.root_a) x_q <= e_v;
    if (cmd_i.root_a) ra_q <= x_q;
    if (cmd_i.emit) begin
      out_weight_q <= span ? sum_q : '0;
      out_span_q   <= span;
      out_ovf_q    <= dropped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= VMAX;
      total_q     <= '0;
      dropped_q   <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      have_q      <= 1'b0;
      found_q     <= 1'b0;
      sum_q       <= '0;
      joins_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        if (total_q < CW'(MAX_EDGES)) total_q <= total_q + CW'(1);
        else dropped_q <= 1'b1;
      end
      if (cmd_i.init_step) k_q <= k_q + VTX_W'(1);
      if (cmd_i.scan_clr || cmd_i.take_min) i_q <= '0;
      else if (cmd_i.min_eval || cmd_i.pick_skip || cmd_i.unite) i_q <= i_q + CW'(1);
      if (cmd_i.scan_clr) found_q <= 1'b0;
      else if (cmd_i.min_eval && cand) found_q <= 1'b1;
      if (cmd_i.take_min) have_q <= 1'b1;
      if (do_union) begin
        sum_q   <= sum_sat;
        joins_q <= joins_q + VTX_W'(1);
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
      if (cmd_i.emit) begin
        total_q     <= '0;
        dropped_q   <= 1'b0;
        k_q         <= '0;
        have_q      <= 1'b0;
        sum_q       <= '0;
        joins_q     <= '0;
      end
    end
  end

endmodule

// File: hdl/minimum_spanning_tree_weight_unit.sv
// Operation: edge words are loaded while idle; after the last edge, the parent
// table is set up, then repeated weight scans pick each distinct weight in turn
// and walk the parent table to the roots of the endpoints of each matching edge,
// and finally the result word is emitted once the output is free.
// Throughput: one graph at a time; the next edge word waits for the result.
// Reset: asynchronous, active low; vertex_count returns to MAX_VERTICES.
`include "minimum_spanning_tree_weight_unit_defines.svh"

module minimum_spanning_tree_weight_unit
  import mstw_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS,
  localparam int VTX_W       = $clog2(MAX_VERTICES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [VTX_W-1:0] cfg_wdata_i,
  mstw_edge_if.sink        item_i,
  mstw_result_if.source    result_o
);

  mstw_cmd_t    cmd;
  mstw_status_t status;
  logic         in_ready;

  mstw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mstw_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .result_o    (result_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  `MSTW_ASSERT(a_result_from_emit, $rose(result_o.valid) |-> $past(cmd.emit), "result without emit")
  `MSTW_ASSERT(a_emit_when_free, cmd.emit |-> status.out_free, "emit over pending result")
  `MSTW_ASSERT(a_cmd_exclusive, $onehot0({cmd.load, cmd.init_step, cmd.min_eval, cmd.unite, cmd.emit}), "command overlap")
  `MSTW_ASSERT_NEVER(a_ready_match, in_ready != item_i.ready, "ready mismatch")

endmodule

// File: tb/mstw_tb_pkg.sv
`timescale 1ns / 100ps

package mstw_tb_pkg;

  localparam int TB_MAX_VERTICES = 64;
  localparam int TB_MAX_EDGES    = 256;

  typedef struct packed {
    logic signed [21:0] tree_weight;
    logic               spanning;
    logic               overflow;
  } tree_result_t;

  typedef struct packed {
    logic [6:0]         end_one;
    logic [6:0]         end_two;
    logic signed [15:0] edge_weight;
    logic               last_edge;
  } edge_word_t;

endpackage

// File: tb/tb_minimum_spanning_tree_weight_unit.sv
`timescale 1ns / 100ps

module tb_minimum_spanning_tree_weight_unit;
  import mstw_pkg::*;
  import mstw_tb_pkg::*;

  localparam int IDLE_LIMIT = 600000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = 7'd64;

  mstw_edge_if   edge_if ();
  mstw_result_if res_if ();

  minimum_spanning_tree_weight_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (edge_if.sink),
    .result_o    (res_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // graph state mirrored from the block
  logic [6:0]         vtx_count = 7'd64;
  logic [6:0]         held_one [TB_MAX_EDGES];
  logic [6:0]         held_two [TB_MAX_EDGES];
  int                 held_wt  [TB_MAX_EDGES];
  int                 held_total = 0;
  bit                 held_dropped = 1'b0;
  tree_result_t       tree_fifo [$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int idle_cycles = 0;
  int edges_sent = 0;
  int graphs_done = 0;
  int spanning_seen = 0;
  int overflow_seen = 0;

  function automatic tree_result_t solve_tree();
    int n, i, j, a, b, tu, tv, tw;
    int par [TB_MAX_VERTICES + 1];
    int rnk [TB_MAX_VERTICES + 1];
    int su [TB_MAX_EDGES];
    int sv [TB_MAX_EDGES];
    int sw [TB_MAX_EDGES];
    longint sum;
    bit span;
    tree_result_t r;
    n = vtx_count;
    if (n < 1) n = 1;
    if (n > TB_MAX_VERTICES) n = TB_MAX_VERTICES;
    for (i = 0; i < held_total; i++) begin
      su[i] = held_one[i];
      sv[i] = held_two[i];
      sw[i] = held_wt[i];
    end
    for (i = 1; i < held_total; i++) begin
      tu = su[i]; tv = sv[i]; tw = sw[i];
      j = i;
      while (j > 0 && sw[j-1] > tw) begin
        su[j] = su[j-1]; sv[j] = sv[j-1]; sw[j] = sw[j-1];
        j--;
      end
      su[j] = tu; sv[j] = tv; sw[j] = tw;
    end
    for (i = 0; i <= n; i++) begin
      par[i] = i;
      rnk[i] = 1;
    end
    sum = 0;
    for (i = 0; i < held_total; i++) begin
      a = su[i];
      b = sv[i];
      if (a < 1 || a > n || b < 1 || b > n) continue;
      while (par[a] != a) a = par[a];
      while (par[b] != b) b = par[b];
      if (a != b) begin
        sum += sw[i];
        if (sum > 2097151) sum = 2097151;
        if (sum < -2097152) sum = -2097152;
        if (rnk[a] < rnk[b]) begin
          tu = a; a = b; b = tu;
        end
        par[b] = a;
        if (rnk[a] == rnk[b]) rnk[a]++;
      end
    end
    span = 1'b1;
    a = 1;
    while (par[a] != a) a = par[a];
    for (i = 2; i <= n; i++) begin
      b = i;
      while (par[b] != b) b = par[b];
      if (b != a) span = 1'b0;
    end
    r.tree_weight = span ? 22'(sum) : '0;
    r.spanning    = span;
    r.overflow    = held_dropped;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic send_edge(input edge_word_t w);
    @(negedge clk_i);
    if ($urandom_range(99) < send_gap_pct) begin
      edge_if.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    edge_if.valid       = 1'b1;
    edge_if.end_one     = w.end_one;
    edge_if.end_two     = w.end_two;
    edge_if.edge_weight = w.edge_weight;
    edge_if.last_edge   = w.last_edge;
    do @(posedge clk_i); while (!edge_if.ready);
    edges_sent++;
    if (held_total < TB_MAX_EDGES) begin
      held_one[held_total] = w.end_one;
      held_two[held_total] = w.end_two;
      held_wt[held_total]  = w.edge_weight;
      held_total++;
    end else begin
      held_dropped = 1'b1;
    end
    if (w.last_edge) begin
      tree_fifo = {tree_fifo, solve_tree()};
      held_total   = 0;
      held_dropped = 1'b0;
      graphs_done++;
    end
  endtask

  task automatic send_one(input int a, input int b, input int wt, input bit last);
    edge_word_t w;
    w.end_one = 7'(a);
    w.end_two = 7'(b);
    w.edge_weight = 16'(wt);
    w.last_edge = last;
    send_edge(w);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    edge_if.valid = 1'b0;
    wait (tree_fifo.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [6:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    vtx_count   = value;
  endtask

  task automatic test_directed();
    send_one(1, 2, 5, 1'b1);
    send_one(64, 63, -32768, 1'b0);
    send_one(0, 127, 32767, 1'b1);
    write_vertex_count(7'd1);
    send_one(1, 1, 7, 1'b1);
    write_vertex_count(7'd2);
    send_one(1, 2, 32767, 1'b0);
    send_one(2, 1, -32768, 1'b0);
    send_one(2, 1, -32768, 1'b0);
    send_one(0, 2, -100, 1'b0);
    send_one(1, 3, -200, 1'b1);
    write_vertex_count(7'd0);
    send_one(1, 1, 3, 1'b1);
    write_vertex_count(7'd127);
    for (int i = 1; i < 64; i++) send_one(i, i + 1, (i % 3) - 1, 1'b0);
    send_one(64, 1, -1, 1'b1);
    write_vertex_count(7'd3);
    send_one(1, 2, 4, 1'b0);
    send_one(2, 3, 4, 1'b0);
    send_one(3, 1, 4, 1'b1);
  endtask

  task automatic test_overflow();
    write_vertex_count(7'd4);
    for (int i = 0; i < 258; i++)
      send_one($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(2, 1), 1'b0);
    send_one(1, 2, 9, 1'b1);
  endtask

  task automatic test_pressure();
    send_one(1, 2, 1, 1'b0);
    send_one(3, 4, 2, 1'b0);
    send_one(2, 3, 3, 1'b1);
    drain_results();
    send_one(4, 1, -5, 1'b1);
  endtask

  task automatic test_random(input int budget);
    int n, sz, a, b, wt, stop_at;
    stop_at = edges_sent + budget;
    while (edges_sent < stop_at) begin
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(4))
          0: write_vertex_count(7'd1);
          1: write_vertex_count(7'd64);
          2: write_vertex_count(7'($urandom_range(127)));
          default: write_vertex_count(7'($urandom_range(10, 2)));
        endcase
      end
      n = vtx_count;
      if (n < 1) n = 1;
      if (n > 64) n = 64;
      sz = (n > 10) ? $urandom_range(16, 1) : $urandom_range(2 * n + 2, 1);
      for (int k = 0; k < sz; k++) begin
        if ($urandom_range(19) == 0) begin
          a = $urandom_range(127);
          b = $urandom_range(127);
        end else begin
          a = $urandom_range(n, 1);
          b = (k < n - 1 && $urandom_range(1)) ? ((a % n) + 1) : $urandom_range(n, 1);
        end
        wt = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(8);
        send_one(a, b, wt, k == sz - 1);
      end
    end
  endtask

  always @(negedge clk_i)
    res_if.ready = ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    tree_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (tree_fifo.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = tree_fifo.pop_front();
        if (res_if.tree_weight !== want.tree_weight)
          report_mismatch("tree_weight", res_if.tree_weight, want.tree_weight);
        if (res_if.spanning !== want.spanning)
          report_mismatch("spanning", res_if.spanning, want.spanning);
        if (res_if.overflow !== want.overflow)
          report_mismatch("overflow", res_if.overflow, want.overflow);
        if (want.spanning) spanning_seen++;
        if (want.overflow) overflow_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((edge_if.valid && edge_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    edge_if.valid       = 1'b0;
    edge_if.end_one     = '0;
    edge_if.end_two     = '0;
    edge_if.edge_weight = '0;
    edge_if.last_edge   = 1'b0;
    res_if.ready        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_gap_pct = 16; recv_stall_pct = 84;
    test_directed();
    test_overflow();
    test_random(480);
    send_gap_pct = 84; recv_stall_pct = 16;
    test_pressure();
    test_random(480);
    send_gap_pct = 0; recv_stall_pct = 0;
    test_random(480);

    drain_results();
    repeat (50) @(posedge clk_i);
    $display("covered %0d edge words in %0d graphs (%0d spanning, %0d overflowed)",
             edges_sent, graphs_done, spanning_seen, overflow_seen);
    $display("vertex counts 0, 1, 2, 64, 127 and random; %0d mismatches", error_count);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
